FILE: rtl/core/tensor_eigen_shape_metrics_unit_assert.svh
// Assertion macros used by the shape metrics port checker.
`ifndef TENSOR_EIGEN_SHAPE_METRICS_UNIT_ASSERT_SVH
`define TENSOR_EIGEN_SHAPE_METRICS_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TESM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TESM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tesm_pkg.sv
// Types and constants of the tensor eigenvalue shape metrics unit.
`timescale 1ns / 1ps
package tesm_pkg;

  localparam int VAL_W      = 24;
  localparam int RATIO_W    = 17;
  localparam int SQSUM_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int EN_W       = 9;
  localparam int MIN_DEN_W  = 16;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 208;

  // Result tdata layout, lowest bit of each field.
  localparam int SPREAD_LSB = 0;
  localparam int LIN_LSB    = 24;
  localparam int PLA_LSB    = 41;
  localparam int SPH_LSB    = 58;
  localparam int SQSUM_LSB  = 75;
  localparam int HALF_LSB   = 107;
  localparam int SHAPE_LSB  = 131;
  localparam int MEAN_LSB   = 155;
  localparam int NORM_LSB   = 179;
  localparam int FIELDS_END = 203;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_DEN = 2'd1;

  // Enable bit of each measure.
  localparam int EN_SPREAD = 0;
  localparam int EN_LIN    = 1;
  localparam int EN_PLA    = 2;
  localparam int EN_SPH    = 3;
  localparam int EN_SQSUM  = 4;
  localparam int EN_HALF   = 5;
  localparam int EN_SHAPE  = 6;
  localparam int EN_MEAN   = 7;
  localparam int EN_NORM   = 8;

  localparam logic [EN_W-1:0]      EN_RESET      = 9'h1FF;
  localparam logic [MIN_DEN_W-1:0] MIN_DEN_RESET = 16'd1;

  localparam logic [VAL_W-1:0] S24_MAX = 24'h7FFFFF;
  localparam logic [VAL_W-1:0] S24_MIN = 24'h800000;

  // ceil(2^32 / 3); exact floor(x / 3) for x below 2^31
  localparam logic [30:0] MEAN_RECIP = 31'h55555556;

  // Measures that bypass the iterative units, delayed alongside them.
  typedef struct packed {
    logic [VAL_W-1:0]   spread;
    logic [VAL_W-1:0]   half;
    logic [SQSUM_W-1:0] sqsum;
    logic [VAL_W-1:0]   mean_q;
    logic               mean_neg;
    logic               sh_ovf;
    logic               sh_neg;
    logic               zdiv;
  } tesm_side_t;

endpackage

FILE: rtl/core/tensor_eigen_shape_metrics_unit.sv
// Tensor eigenvalue shape metrics: Westin anisotropy ratios and related measures.
//
// One tensor (major, intermediate, minor eigenvalue, signed Q8.FRAC_BITS) enters per
// cycle; its nine measures pass stages 1 and 2, DEPTH = max(24, FRAC_BITS+1) iterative
// stages and the output register. The depth is set by the 24-step square root of the
// squared-eigenvalue sum and by the three anisotropy dividers and the shape divider,
// which resolve one quotient bit per stage. The whole pipe advances together and
// holds while a finished result waits on out_tready; with out_tready high the block
// takes a new transaction every cycle. Configuration takes effect on items accepted
// after the write and is to be changed only while the pipe is empty.
`timescale 1ns / 1ps
module tensor_eigen_shape_metrics_unit
  import tesm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // major_value [23:0], middle_value [47:24], minor_value [71:48]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // spread [23:0], linear_ratio [40:24], planar_ratio [57:41],
  // spherical_ratio [74:58], square_sum [106:75], half_spread [130:107],
  // shape_ratio [154:131], mean_value [178:155], norm_value [202:179], zeros above
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // shape_zero_divide [0]
  output logic                   out_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int QR_W   = FRAC_BITS + 1;
  localparam int DEN_W  = 25;
  localparam int RNUM_W = DEN_W + QR_W;
  localparam int SH_Q_W = 24;
  localparam int SHN_W  = DEN_W + SH_Q_W;
  localparam int SQRT_N = 24;
  localparam int DEPTH  = (QR_W > SQRT_N) ? QR_W : SQRT_N;

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  // Configuration registers
  logic [EN_W-1:0]      enable_r;
  logic [MIN_DEN_W-1:0] min_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= EN_RESET;
      min_den_r <= MIN_DEN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_ENABLE:  enable_r  <= cfg_data[EN_W-1:0];
        CFG_IDX_MIN_DEN: min_den_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: magnitudes, differences, sum, squares
  logic signed [VAL_W-1:0] a, b, c;
  logic [VAL_W-1:0] ma, mb, mc;
  logic [46:0]      sqa, sqb, sqc;

  assign a  = in_tdata[23:0];
  assign b  = in_tdata[47:24];
  assign c  = in_tdata[71:48];
  assign ma = a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
  assign mb = b[VAL_W-1] ? VAL_W'(-b) : VAL_W'(b);
  assign mc = c[VAL_W-1] ? VAL_W'(-c) : VAL_W'(c);
  assign sqa = ma * ma;
  assign sqb = mb * mb;
  assign sqc = mc * mc;

  logic                v1_r;
  logic [VAL_W-1:0]    s1_ma_r, s1_mb_r, s1_mc_r;
  logic [46:0]         s1_sqa_r, s1_sqb_r, s1_sqc_r;
  logic signed [24:0]  s1_dac_r, s1_dab_r;
  logic signed [25:0]  s1_tot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ma_r  <= ma;
      s1_mb_r  <= mb;
      s1_mc_r  <= mc;
      s1_sqa_r <= sqa;
      s1_sqb_r <= sqb;
      s1_sqc_r <= sqc;
      s1_dac_r <= 25'(a) - 25'(c);
      s1_dab_r <= 25'(a) - 25'(b);
      s1_tot_r <= 26'(a) + 26'(b) + 26'(c);
    end
  end

  // Stage 2: sort, denominator, operand setup for the iterative units, bypass measures
  logic [DEN_W-1:0]     sum, hi, lo, mid, den, den_floor;
  logic [DEN_W-1:0]     x1, x2, x3;
  logic [47:0]          raw2, sqs;
  logic [24:0]          abs_ac, abs_ab, abs_tot;
  logic [SHN_W-1:0]     sh_num;
  logic                 sh_ovf;
  logic signed [24:0]   half_v;
  logic [55:0]          mprod;
  tesm_side_t           side_nxt;

  always_comb begin
    sum = DEN_W'(s1_ma_r) + DEN_W'(s1_mb_r) + DEN_W'(s1_mc_r);
    hi  = DEN_W'(s1_ma_r);
    if (DEN_W'(s1_mb_r) > hi) hi = DEN_W'(s1_mb_r);
    if (DEN_W'(s1_mc_r) > hi) hi = DEN_W'(s1_mc_r);
    lo  = DEN_W'(s1_ma_r);
    if (DEN_W'(s1_mb_r) < lo) lo = DEN_W'(s1_mb_r);
    if (DEN_W'(s1_mc_r) < lo) lo = DEN_W'(s1_mc_r);
    mid = sum - hi - lo;
    den_floor = (min_den_r == '0) ? DEN_W'(1) : DEN_W'(min_den_r);
    den = (sum > den_floor) ? sum : den_floor;
    x1  = hi - mid;
    x2  = (mid - lo) << 1;
    x3  = (lo << 1) + lo;
  end

  assign raw2 = 48'(s1_sqa_r) + 48'(s1_sqb_r) + 48'(s1_sqc_r);
  assign sqs  = (48'(s1_sqa_r) >> FRAC_BITS) + (48'(s1_sqb_r) >> FRAC_BITS)
              + (48'(s1_sqc_r) >> FRAC_BITS);

  assign abs_ac  = s1_dac_r[24] ? 25'(-s1_dac_r) : 25'(s1_dac_r);
  assign abs_ab  = s1_dab_r[24] ? 25'(-s1_dab_r) : 25'(s1_dab_r);
  assign abs_tot = s1_tot_r[25] ? 25'(-s1_tot_r) : 25'(s1_tot_r);
  assign sh_num  = SHN_W'(abs_ab) << FRAC_BITS;
  // quotient would need more than 24 bits
  assign sh_ovf  = sh_num >= (SHN_W'(abs_ac) << SH_Q_W);
  assign half_v  = (s1_dac_r + $signed({24'd0, s1_dac_r[24]})) >>> 1;
  assign mprod   = abs_tot * MEAN_RECIP;

  always_comb begin
    side_nxt.spread   = abs_ac[VAL_W-1:0];
    side_nxt.half     = half_v[VAL_W-1:0];
    side_nxt.sqsum    = (|sqs[47:SQSUM_W]) ? '1 : sqs[SQSUM_W-1:0];
    side_nxt.mean_q   = mprod[55:32];
    side_nxt.mean_neg = s1_tot_r[25];
    side_nxt.sh_ovf   = sh_ovf;
    side_nxt.sh_neg   = s1_dab_r[24] ^ s1_dac_r[24];
    side_nxt.zdiv     = (s1_dac_r == '0);
  end

  logic               v2_r;
  logic [RNUM_W-1:0]  s2_num1_r, s2_num2_r, s2_num3_r;
  logic [DEN_W-1:0]   s2_den_r;
  logic [SHN_W-1:0]   s2_shn_r;
  logic [24:0]        s2_shd_r;
  logic [47:0]        s2_raw2_r;
  tesm_side_t         side_r [DEPTH+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_num1_r <= RNUM_W'(x1) << FRAC_BITS;
      s2_num2_r <= RNUM_W'(x2) << FRAC_BITS;
      s2_num3_r <= RNUM_W'(x3) << FRAC_BITS;
      s2_den_r  <= den;
      s2_shn_r  <= sh_ovf ? '0 : sh_num;
      s2_shd_r  <= abs_ac;
      s2_raw2_r <= raw2;
      side_r[0] <= side_nxt;
    end
  end

  // Iterative stages: dividers, square root, delayed side measures
  logic [QR_W-1:0]   q_lin, q_pla, q_sph;
  logic [SH_Q_W-1:0] q_shape;

  tesm_pipe_div #(.DEN_W(DEN_W), .Q_W(QR_W), .DEPTH(DEPTH)) u_div_lin (
    .clk(clk), .en(adv), .num_i(s2_num1_r), .den_i(s2_den_r), .quo_o(q_lin)
  );
  tesm_pipe_div #(.DEN_W(DEN_W), .Q_W(QR_W), .DEPTH(DEPTH)) u_div_pla (
    .clk(clk), .en(adv), .num_i(s2_num2_r), .den_i(s2_den_r), .quo_o(q_pla)
  );
  tesm_pipe_div #(.DEN_W(DEN_W), .Q_W(QR_W), .DEPTH(DEPTH)) u_div_sph (
    .clk(clk), .en(adv), .num_i(s2_num3_r), .den_i(s2_den_r), .quo_o(q_sph)
  );
  tesm_pipe_div #(.DEN_W(DEN_W), .Q_W(SH_Q_W), .DEPTH(DEPTH)) u_div_shape (
    .clk(clk), .en(adv), .num_i(s2_shn_r), .den_i(s2_shd_r), .quo_o(q_shape)
  );

  logic [47:0]      sq_rem_r  [SQRT_N-1];
  logic [VAL_W-1:0] sq_root_r [DEPTH];
  logic             vd_r      [DEPTH];

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_sqrt
    logic [VAL_W-1:0] root_in, root_nxt;

    if (gi == 0) begin : g_first
      assign root_in = '0;
    end else begin : g_next
      assign root_in = sq_root_r[gi-1];
    end

    if (gi < SQRT_N) begin : g_step
      localparam int B = SQRT_N - 1 - gi;
      logic [47:0] rem_in, trial;
      logic        ge;

      if (gi == 0) begin : g_src0
        assign rem_in = s2_raw2_r;
      end else begin : g_srcn
        assign rem_in = sq_rem_r[gi-1];
      end

      // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
      assign trial    = (48'(root_in) << (B + 1)) | (48'(1) << (2 * B));
      assign ge       = rem_in >= trial;
      assign root_nxt = ge ? (root_in | (VAL_W'(1) << B)) : root_in;

      if (gi < SQRT_N - 1) begin : g_keep
        always_ff @(posedge clk) begin
          if (adv) begin
            sq_rem_r[gi] <= ge ? rem_in - trial : rem_in;
          end
        end
      end
    end else begin : g_pass
      assign root_nxt = root_in;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_root_r[gi]  <= root_nxt;
        side_r[gi + 1] <= side_r[gi];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[gi] <= 1'b0;
      end else if (adv) begin
        vd_r[gi] <= (gi == 0) ? v2_r : vd_r[(gi == 0) ? 0 : gi - 1];
      end
    end
  end

  // Output stage: saturation, signs, enable mask
  logic [RATIO_W-1:0] lin, pla, sph;

  if (QR_W > RATIO_W) begin : g_rsat
    assign lin = (|q_lin[QR_W-1:RATIO_W]) ? '1 : q_lin[RATIO_W-1:0];
    assign pla = (|q_pla[QR_W-1:RATIO_W]) ? '1 : q_pla[RATIO_W-1:0];
    assign sph = (|q_sph[QR_W-1:RATIO_W]) ? '1 : q_sph[RATIO_W-1:0];
  end else begin : g_rext
    assign lin = RATIO_W'(q_lin);
    assign pla = RATIO_W'(q_pla);
    assign sph = RATIO_W'(q_sph);
  end

  tesm_side_t         sd;
  logic [VAL_W-1:0]   shape, mean;
  logic [OUT_TDATA_W-1:0] data_nxt;

  assign sd = side_r[DEPTH];

  always_comb begin
    if (sd.zdiv) begin
      shape = '0;
    end else if (sd.sh_ovf) begin
      shape = sd.sh_neg ? S24_MIN : S24_MAX;
    end else if (!sd.sh_neg) begin
      shape = (q_shape > S24_MAX) ? S24_MAX : q_shape;
    end else begin
      shape = (q_shape > S24_MIN) ? S24_MIN : VAL_W'(-q_shape);
    end
    mean = sd.mean_neg ? VAL_W'(-sd.mean_q) : sd.mean_q;

    data_nxt = '0;
    data_nxt[SPREAD_LSB +: VAL_W]  = enable_r[EN_SPREAD] ? sd.spread : '0;
    data_nxt[LIN_LSB +: RATIO_W]   = enable_r[EN_LIN]    ? lin : '0;
    data_nxt[PLA_LSB +: RATIO_W]   = enable_r[EN_PLA]    ? pla : '0;
    data_nxt[SPH_LSB +: RATIO_W]   = enable_r[EN_SPH]    ? sph : '0;
    data_nxt[SQSUM_LSB +: SQSUM_W] = enable_r[EN_SQSUM]  ? sd.sqsum : '0;
    data_nxt[HALF_LSB +: VAL_W]    = enable_r[EN_HALF]   ? sd.half : '0;
    data_nxt[SHAPE_LSB +: VAL_W]   = enable_r[EN_SHAPE]  ? shape : '0;
    data_nxt[MEAN_LSB +: VAL_W]    = enable_r[EN_MEAN]   ? mean : '0;
    data_nxt[NORM_LSB +: VAL_W]    = enable_r[EN_NORM]   ? sq_root_r[DEPTH-1] : '0;
  end

  logic                   out_tvalid_r, out_tuser_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= vd_r[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= data_nxt;
      out_tuser_r <= enable_r[EN_SHAPE] & sd.zdiv;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

FILE: rtl/core/tesm_pipe_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module tesm_pipe_div
  import tesm_pkg::*;
#(
  parameter int DEN_W = 25,
  parameter int Q_W   = 17,
  parameter int DEPTH = 24
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [DEN_W+Q_W-1:0]   num_i,   // must be below den_i << Q_W
  input  logic [DEN_W-1:0]       den_i,
  output logic [Q_W-1:0]         quo_o
);

  localparam int NUM_W = DEN_W + Q_W;

  logic [NUM_W-1:0] rem_r [Q_W-1];
  logic [DEN_W-1:0] den_r [Q_W-1];
  logic [Q_W-1:0]   q_r   [DEPTH];

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_stage
    logic [Q_W-1:0] q_in, q_nxt;

    if (gi == 0) begin : g_first
      assign q_in = '0;
    end else begin : g_next
      assign q_in = q_r[gi-1];
    end

    if (gi < Q_W) begin : g_step
      localparam int B = Q_W - 1 - gi;
      logic [NUM_W-1:0] rem_in, trial;
      logic [DEN_W-1:0] den_in;
      logic             ge;

      if (gi == 0) begin : g_src0
        assign rem_in = num_i;
        assign den_in = den_i;
      end else begin : g_srcn
        assign rem_in = rem_r[gi-1];
        assign den_in = den_r[gi-1];
      end

      assign trial = NUM_W'(den_in) << B;
      assign ge    = rem_in >= trial;
      assign q_nxt = ge ? (q_in | (Q_W'(1) << B)) : q_in;

      if (gi < Q_W - 1) begin : g_keep
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[gi] <= ge ? rem_in - trial : rem_in;
            den_r[gi] <= den_in;
          end
        end
      end
    end else begin : g_pass
      assign q_nxt = q_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[gi] <= q_nxt;
      end
    end
  end

  assign quo_o = q_r[DEPTH-1];

endmodule

FILE: rtl/core/tesm_checker.sv
// Port-level checker for the shape metrics unit, bound to the top level.
`timescale 1ns / 1ps
`include "tensor_eigen_shape_metrics_unit_assert.svh"
module tesm_port_checker
  import tesm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // A waiting result must not change.
  `TESM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // With the output register empty the pipe must take input.
  `TESM_ASSERT_NOW(a_in_ready, !out_tvalid, in_tready, "input blocked with empty output")

  // Undefined shape ratio is reported as zero.
  `TESM_ASSERT_NOW(a_zdiv_zero, out_tvalid && out_tuser, out_tdata[SHAPE_LSB +: VAL_W] == '0, "shape ratio nonzero on zero divide")

  // Ratios never exceed 17'h10000, which is one at FRAC_BITS = 16, when FRAC_BITS is at most 16.
  `TESM_ASSERT_NOW(a_ratio_max, out_tvalid && (FRAC_BITS <= 16), (out_tdata[LIN_LSB +: RATIO_W] <= 17'h10000) && (out_tdata[PLA_LSB +: RATIO_W] <= 17'h10000) && (out_tdata[SPH_LSB +: RATIO_W] <= 17'h10000), "ratio above one")

endmodule

bind tensor_eigen_shape_metrics_unit tesm_port_checker #(.FRAC_BITS(FRAC_BITS)) u_tesm_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
